// ===== src/iis_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iis_pkg: shared definitions of the streaming integral image block
// Sizes, configuration register indexes and the types that pass between the
// front end, the item queue and the back end.
// ----------------------------------------------------------------------------
package iis_pkg;

  localparam int unsigned MaxWidth   = 2048;
  localparam int unsigned MaxHeight  = 2048;
  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned RowW       = $clog2(MaxHeight);
  localparam int unsigned SizeW      = 12;
  localparam int unsigned PixW       = 8;
  localparam int unsigned TermW      = 2 * PixW;
  localparam int unsigned RowSumW    = 27;
  localparam int unsigned SumW       = 38;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);

  localparam logic [CfgIdxW-1:0] CfgSquared = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgWidth   = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgHeight  = CfgIdxW'(2);

  // Active configuration, sizes already clamped and given as last position.
  typedef struct packed {
    logic            squared;
    logic [ColW-1:0] col_last;
    logic [RowW-1:0] row_last;
  } iis_cfg_t;

  // One classified pixel on its way from the front end to the back end.
  typedef struct packed {
    logic [ColW-1:0]    col;
    logic               first_row;
    logic [RowSumW-1:0] row_sum;
    logic               row_end;
    logic               frame_end;
  } iis_item_t;

endpackage

`default_nettype wire

// ===== src/integral_image_stream_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// integral_image_stream_top: streaming integral image
// Takes 8-bit pixels in raster order and returns the summed-area value of
// each pixel, plain or squared, with row and frame end flags.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while the queue has room and gives one
// result per pixel, in order. An accepted pixel's item is written into the
// item queue, reads the line store as it leaves the queue, and its result
// then loads the output register.
// The line store has one write and one read per cycle, which sets the rate at
// one pixel per clock when the output is not stalled; a result from the row
// above is forwarded when the next read hits the same column.
// A queue of four items sits between the pixel intake and the line store, so
// the input keeps flowing after the output stalls until the queue is full.
// Image sizes of zero act as one, above 2048 as 2048. The user must write
// configuration only while no pixel is in flight; the block does not check.
// ----------------------------------------------------------------------------
module integral_image_stream_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [iis_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [iis_pkg::SizeW-1:0]         cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [iis_pkg::PixW-1:0]          pixel_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [iis_pkg::SumW-1:0]               area_sum_o,
  output logic                                   row_end_o,
  output logic                                   frame_end_o
);
  import iis_pkg::*;

  logic             squared_q;
  logic [SizeW-1:0] width_q;
  logic [SizeW-1:0] height_q;
  iis_cfg_t         cfg;
  logic             push;
  logic             pop;
  logic             queue_full;
  logic             queue_valid;
  iis_item_t        front_item;
  iis_item_t        queue_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      squared_q <= 1'b0;
      width_q   <= SizeW'(640);
      height_q  <= SizeW'(480);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSquared: squared_q <= cfg_data_i[0];
        CfgWidth:   width_q   <= cfg_data_i;
        CfgHeight:  height_q  <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Clamp the sizes and turn them into the last column and row position.
  always_comb begin
    cfg.squared = squared_q;
    if (width_q == '0) begin
      cfg.col_last = '0;
    end else if (width_q > SizeW'(MaxWidth)) begin
      cfg.col_last = ColW'(MaxWidth - 1);
    end else begin
      cfg.col_last = ColW'(width_q - SizeW'(1));
    end
    if (height_q == '0) begin
      cfg.row_last = '0;
    end else if (height_q > SizeW'(MaxHeight)) begin
      cfg.row_last = RowW'(MaxHeight - 1);
    end else begin
      cfg.row_last = RowW'(height_q - SizeW'(1));
    end
  end

  iis_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .pixel_i      (pixel_i),
    .in_stall_o   (in_stall_o),
    .queue_full_i (queue_full),
    .push_o       (push),
    .item_o       (front_item)
  );

  iis_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .item_o  (queue_item)
  );

  iis_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (queue_valid),
    .item_i       (queue_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .area_sum_o   (area_sum_o),
    .row_end_o    (row_end_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

`default_nettype wire

// ===== src/iis_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iis_front: pixel intake and position tracking
// Accepts pixels, keeps the column and row counters and the running row sum,
// and hands one classified item per pixel to the queue.
// ----------------------------------------------------------------------------
module iis_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire iis_pkg::iis_cfg_t          cfg_i,
  input  wire logic                       in_valid_i,
  input  wire logic [iis_pkg::PixW-1:0]   pixel_i,
  output logic                            in_stall_o,
  input  wire logic                       queue_full_i,
  output logic                            push_o,
  output iis_pkg::iis_item_t              item_o
);
  import iis_pkg::*;

  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [RowSumW-1:0] row_sum_q, row_sum_d;
  logic [TermW-1:0]   term;
  logic [RowSumW-1:0] row_sum_new;
  logic               last_col;
  logic               last_row;
  logic               accept;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign push_o     = accept;

  assign term = cfg_i.squared ? ({{PixW{1'b0}}, pixel_i} * {{PixW{1'b0}}, pixel_i})
                              : {{PixW{1'b0}}, pixel_i};
  assign row_sum_new = row_sum_q + {{(RowSumW - TermW){1'b0}}, term};

  // A counter beyond a shrunk size ends its row or frame at once.
  assign last_col = col_q >= cfg_i.col_last;
  assign last_row = row_q >= cfg_i.row_last;

  always_comb begin
    item_o.col       = col_q;
    item_o.first_row = (row_q == '0);
    item_o.row_sum   = row_sum_new;
    item_o.row_end   = last_col;
    item_o.frame_end = last_col && last_row;
  end

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    row_sum_d = row_sum_q;
    if (accept) begin
      if (last_col) begin
        col_d     = '0;
        row_sum_d = '0;
        row_d     = last_row ? '0 : row_q + RowW'(1);
      end else begin
        col_d     = col_q + ColW'(1);
        row_sum_d = row_sum_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      row_sum_q <= '0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      row_sum_q <= row_sum_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/iis_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iis_queue: short item queue
// A small first-in first-out buffer that lets the front end and the back end
// stall independently.
// ----------------------------------------------------------------------------
module iis_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire iis_pkg::iis_item_t item_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output iis_pkg::iis_item_t      item_o
);
  import iis_pkg::*;

  iis_item_t          slot_q [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]     count_q, count_d;

  assign full_o  = (count_q == (QPtrW + 1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (QPtrW + 1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QPtrW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/iis_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iis_back: line store and result stage
// Reads the previous row's value for the item's column, adds the row sum,
// writes the result back into the line store and holds it for transfer.
// ----------------------------------------------------------------------------
module iis_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       item_valid_i,
  input  wire iis_pkg::iis_item_t         item_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [iis_pkg::SumW-1:0]        area_sum_o,
  output logic                            row_end_o,
  output logic                            frame_end_o
);
  import iis_pkg::*;

  logic [SumW-1:0] line_mem [MaxWidth];

  logic            s2_valid_q, s2_valid_d;
  iis_item_t       s2_item_q;
  logic [SumW-1:0] rd_q;
  logic [SumW-1:0] sum;
  logic            s2_adv;
  logic            out_valid_q, out_valid_d;
  logic [SumW-1:0] area_sum_q;
  logic            row_end_q;
  logic            frame_end_q;

  assign s2_adv = s2_valid_q && (!out_valid_q || !out_stall_i);
  assign pop_o  = item_valid_i && (!s2_valid_q || s2_adv);

  assign sum = s2_item_q.first_row
             ? {{(SumW - RowSumW){1'b0}}, s2_item_q.row_sum}
             : rd_q + {{(SumW - RowSumW){1'b0}}, s2_item_q.row_sum};

  // The result leaving the second stage is written in the same cycle that the
  // next item reads; when both hit one column the fresh sum is forwarded.
  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      line_mem[s2_item_q.col] <= sum;
    end
    if (pop_o) begin
      rd_q      <= (s2_adv && (s2_item_q.col == item_i.col)) ? sum : line_mem[item_i.col];
      s2_item_q <= item_i;
    end
    if (s2_adv) begin
      area_sum_q  <= sum;
      row_end_q   <= s2_item_q.row_end;
      frame_end_q <= s2_item_q.frame_end;
    end
  end

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (pop_o) begin
      s2_valid_d = 1'b1;
    end else if (s2_adv) begin
      s2_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s2_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign area_sum_o  = area_sum_q;
  assign row_end_o   = row_end_q;
  assign frame_end_o = frame_end_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the streaming integral image block
// Streams pixel frames through the block under random input gaps and output
// stalls. A behavioral summed-area predictor with its own line store tracks
// every accepted pixel. Each result is compared field by field with the
// oldest predicted sum. Frame sizes and the squared mode are changed between
// bursts, at frame boundaries and in mid-frame.
// ----------------------------------------------------------------------------
module tb_top;
  import iis_pkg::*;

  localparam int unsigned RandomPixels   = 650;
  localparam int unsigned MaxBurstPixels = 160;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned MaxReports     = 40;

  typedef struct packed {
    logic [SumW-1:0] area_sum;
    logic            row_end;
    logic            frame_end;
  } area_result_t;

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               cfg_we   = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx  = CfgSquared;
  logic [SizeW-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [PixW-1:0]    pixel    = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [SumW-1:0]    area_sum;
  logic               row_end;
  logic               frame_end;

  // Predictor state: register copies, line store, row sum and position.
  logic               sq_mode;
  logic [SizeW-1:0]   width_reg;
  logic [SizeW-1:0]   height_reg;
  logic [SumW-1:0]    line_store [MaxWidth];
  int unsigned        written_cols;
  logic [RowSumW-1:0] row_acc;
  int unsigned        col_pos;
  int unsigned        row_pos;

  area_result_t pending_sums [$];
  bit           in_idle;
  bit           out_idle;
  int unsigned  pixels_sent;
  int unsigned  sums_checked;
  int unsigned  frames_done;
  int unsigned  cfg_writes;
  int unsigned  mismatches;

  integral_image_stream_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .pixel_i     (pixel),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .area_sum_o  (area_sum),
    .row_end_o   (row_end),
    .frame_end_o (frame_end)
  );

  always #2 clk = ~clk;

  function automatic int unsigned draw_wait(input bit enabled);
    return enabled ? $urandom_range(0, 19) : 0;
  endfunction

  function automatic int unsigned eff_size(input logic [SizeW-1:0] v,
                                           input int unsigned max_size);
    if (v == '0) return 1;
    if (v > max_size) return max_size;
    return v;
  endfunction

  // Works out the summed-area result of one accepted pixel and advances the
  // row sum, the line store and the frame position.
  function automatic void advance_integral(input logic [PixW-1:0] p);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    logic [TermW-1:0] term;
    area_result_t     r;
    w = eff_size(width_reg, MaxWidth);
    h = eff_size(height_reg, MaxHeight);
    c = (col_pos >= MaxWidth) ? MaxWidth - 1 : col_pos;
    term = sq_mode ? p * p : TermW'(p);
    row_acc = row_acc + RowSumW'(term);
    if (row_pos == 0) begin
      r.area_sum = SumW'(row_acc);
    end else begin
      r.area_sum = line_store[c] + SumW'(row_acc);
    end
    line_store[c] = r.area_sum;
    if (c + 1 > written_cols) written_cols = c + 1;
    r.row_end = (col_pos >= w - 1);
    r.frame_end = r.row_end && (row_pos >= h - 1);
    pending_sums.push_back(r);
    if (r.row_end) begin
      col_pos = 0;
      row_acc = '0;
      if (r.frame_end) begin
        row_pos = 0;
        frames_done++;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Entered and left just after a rising edge. The valid stays high when the
  // next transfer follows without a gap.
  task automatic send_pixel(input logic [PixW-1:0] p);
    int unsigned gap;
    gap = draw_wait(in_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_integral(p);
    pixels_sent++;
  endtask

  // Holds the input back until every predicted sum has been delivered.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [SizeW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgSquared: sq_mode    = val[0];
      CfgWidth:   width_reg  = val;
      CfgHeight:  height_reg = val;
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    in_idle  = 1'b1;
    out_idle = 1'b1;
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'hFF);
  endtask

  task automatic test_shrink_midframe();
    wait_for_idle();
    // The column counter is already past the new last column.
    write_reg(CfgWidth, 12'd2);
    send_pixel(8'h01);
    wait_for_idle();
    // A height of zero acts as one row, so the current row closes the frame.
    write_reg(CfgHeight, 12'd0);
    send_pixel(8'h80);
    send_pixel(8'h7F);
  endtask

  task automatic test_single_pixel_frames();
    wait_for_idle();
    write_reg(CfgWidth, 12'd0);
    write_reg(CfgSquared, 12'hFFF);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h80);
  endtask

  task automatic test_squared_mode();
    wait_for_idle();
    write_reg(CfgWidth, 12'd3);
    write_reg(CfgHeight, 12'd2);
    send_pixel(8'hFF);
    send_pixel(8'hFF);
    wait_for_idle();
    // Only bit 0 counts; the plain mode applies from the next pixel on.
    write_reg(CfgSquared, 12'hFFE);
    send_pixel(8'hFF);
    send_pixel(8'h01);
    send_pixel(8'hFE);
    send_pixel(8'hFF);
  endtask

  task automatic test_saturated_sizes();
    wait_for_idle();
    write_reg(CfgSquared, 12'd1);
    write_reg(CfgWidth, 12'hFFF);
    write_reg(CfgHeight, 12'hFFF);
    repeat (4) send_pixel(8'hFF);
    wait_for_idle();
    write_reg(CfgWidth, 12'd2);
    send_pixel(8'hFF);
    send_pixel(8'hFF);
    send_pixel(8'hFF);
  endtask

  task automatic test_random_frames();
    int unsigned      sent;
    int unsigned      w;
    int unsigned      h;
    int unsigned      remaining;
    int unsigned      burst;
    int unsigned      flavor;
    int unsigned      cap;
    logic [SizeW-1:0] val;
    sent = 0;
    while (sent < RandomPixels) begin
      wait_for_idle();
      in_idle  = ($urandom_range(0, 2) != 0);
      out_idle = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 1) == 1) write_reg(CfgSquared, SizeW'($urandom));
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       val = '0;
          1:       val = SizeW'($urandom_range(9, 40));
          2:       val = SizeW'($urandom_range(MaxWidth + 1, 4095));
          default: val = SizeW'($urandom_range(1, 8));
        endcase
        // Below row 0 a wider row would read line-store columns never written.
        if (row_pos != 0 && eff_size(val, MaxWidth) > written_cols) begin
          cap = (written_cols < 40) ? written_cols : 40;
          val = SizeW'($urandom_range(1, cap));
        end
        write_reg(CfgWidth, val);
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       val = '0;
          1:       val = SizeW'($urandom_range(7, 4095));
          default: val = SizeW'($urandom_range(1, 6));
        endcase
        write_reg(CfgHeight, val);
      end
      w = eff_size(width_reg, MaxWidth);
      h = eff_size(height_reg, MaxHeight);
      remaining = ((col_pos >= w - 1) ? 1 : w - col_pos) +
                  ((row_pos >= h - 1) ? 0 : (h - 1 - row_pos) * w);
      // Mostly finish the frame and add whole frames; sometimes stop midway.
      if ($urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, MaxBurstPixels);
      end else begin
        burst = remaining + $urandom_range(0, 2) * w * h;
      end
      if (burst > MaxBurstPixels) burst = MaxBurstPixels;
      flavor = $urandom_range(0, 7);
      repeat (burst) begin
        case (flavor)
          0:       send_pixel(8'hFF);
          1:       send_pixel(($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00);
          default: send_pixel(PixW'($urandom));
        endcase
      end
      sent += burst;
    end
  endtask

  initial begin : result_checker
    area_result_t want;
    int unsigned  stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_valid && !out_stall) begin
          if (pending_sums.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no sum expected", area_sum));
          end else begin
            want = pending_sums.pop_front();
            sums_checked++;
            if (area_sum !== want.area_sum)
              report_mismatch($sformatf("area_sum %0d, expected %0d", area_sum,
                                        want.area_sum));
            if (row_end !== want.row_end)
              report_mismatch($sformatf("row_end %b, expected %b", row_end, want.row_end));
            if (frame_end !== want.frame_end)
              report_mismatch($sformatf("frame_end %b, expected %b", frame_end,
                                        want.frame_end));
          end
          stall_left = draw_wait(out_idle);
          out_stall <= (stall_left != 0);
        end else if (stall_left != 0) begin
          stall_left--;
          if (stall_left == 0) out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    sq_mode      = 1'b0;
    width_reg    = 12'd640;
    height_reg   = 12'd480;
    row_acc      = '0;
    col_pos      = 0;
    row_pos      = 0;
    written_cols = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_shrink_midframe();
    test_single_pixel_frames();
    test_squared_mode();
    test_saturated_sizes();
    test_random_frames();
    wait_for_idle();
    $display("Streamed %0d pixels, %0d complete frames, %0d register writes.",
             pixels_sent, frames_done, cfg_writes);
    $display("Checked %0d summed-area results, %0d mismatches.", sums_checked, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Run timed out with %0d sums outstanding.", pending_sums.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
